>>> src/lepm_pkg.sv
package lepm_pkg;

   // field widths
   localparam int TS_W    = 48;
   localparam int VAL_W   = 32;
   localparam int AVG_W   = 48;
   localparam int ALPHA_W = 16;

   // product accumulator of the average update
   localparam int ACC_W   = AVG_W + ALPHA_W;
   localparam int CHUNKS  = AVG_W / ALPHA_W;
   localparam int CHUNK_W = $clog2(CHUNKS);

   // configuration and window defaults
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd7864;
   localparam int WINDOW_DEPTH_DEF = 32;

   // percentile rank as a running fraction: rank = floor((used-1)*P95_NUM/P95_DEN)
   localparam int P95_NUM = 95;
   localparam int P95_DEN = 100;
   localparam int FRAC_W  = 7;

   localparam logic [VAL_W-1:0] COUNT_MAX = '1;

endpackage

>>> src/lepm_if.sv
// frame timestamps in
interface lepm_req_if import lepm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TS_W-1:0]   decode_start_ms;
   logic [TS_W-1:0]   decode_end_ms;
   logic [TS_W-1:0]   present_ms;

   modport source (output valid, decode_start_ms, decode_end_ms, present_ms, input ready);
   modport sink   (input valid, decode_start_ms, decode_end_ms, present_ms, output ready);
endinterface

// statistics out
interface lepm_rsp_if import lepm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [AVG_W-1:0]  avg_decode_q16;
   logic [AVG_W-1:0]  avg_present_q16;
   logic [VAL_W-1:0]  p95_decode;
   logic [VAL_W-1:0]  p95_present;
   logic [VAL_W-1:0]  last_decode;
   logic [VAL_W-1:0]  last_present;
   logic [VAL_W-1:0]  frames_timed;

   modport source (output valid, avg_decode_q16, avg_present_q16, p95_decode, p95_present,
                   last_decode, last_present, frames_timed, input ready);
   modport sink   (input valid, avg_decode_q16, avg_present_q16, p95_decode, p95_present,
                   last_decode, last_present, frames_timed, output ready);
endinterface

>>> src/latency_ema_percentile_monitor_unit.sv
// Per metric and frame: an average update, then a delete pass (only with a full window) and
//   an insert pass over the sorted window memory, one entry per cycle; then both percentiles
//   are read and the word waits for a free output register. A new frame is accepted only in
//   idle, after the last one is handed on; a frame with zero start or end is dropped on accept.
//   Reset (synchronous, active high): alpha to 7864, averages, count, ring slot and window fill
//   cleared; window memories are not cleared, only written entries are ever read.
module latency_ema_percentile_monitor_unit import lepm_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [ALPHA_W-1:0] csr_wr_data,
   lepm_req_if.sink           req_chan,
   lepm_rsp_if.source         rsp_chan
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EMA_GO  = 4'd1;
   localparam logic [3:0] S_EMA_WT  = 4'd2;
   localparam logic [3:0] S_DEL     = 4'd3;
   localparam logic [3:0] S_INS     = 4'd4;
   localparam logic [3:0] S_INS_END = 4'd5;
   localparam logic [3:0] S_P95_A   = 4'd6;
   localparam logic [3:0] S_P95_B   = 4'd7;
   localparam logic [3:0] S_P95_C   = 4'd8;

   // control state
   logic [3:0]         state_ff, state_in;
   logic               metric_ff, metric_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               flag_ff, flag_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [AVG_W-1:0]   dec_avg_ff, dec_avg_in;
   logic [AVG_W-1:0]   pre_avg_ff, pre_avg_in;
   logic [VAL_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [IDX_W-1:0]   rank_ff, rank_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload
   logic [VAL_W-1:0]   dec_ff, dec_in;
   logic [VAL_W-1:0]   lat_ff, lat_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [VAL_W-1:0]   p95_dec_ff, p95_dec_in;
   logic [AVG_W-1:0]   o_avg_dec_ff, o_avg_dec_in;
   logic [AVG_W-1:0]   o_avg_pre_ff, o_avg_pre_in;
   logic [VAL_W-1:0]   o_p95_dec_ff, o_p95_dec_in;
   logic [VAL_W-1:0]   o_p95_pre_ff, o_p95_pre_in;
   logic [VAL_W-1:0]   o_last_dec_ff, o_last_dec_in;
   logic [VAL_W-1:0]   o_last_pre_ff, o_last_pre_in;
   logic [VAL_W-1:0]   o_count_ff, o_count_in;

   // window memories: ring in arrival order, and the same samples kept sorted
   logic [VAL_W-1:0]   ring_mem [2][WINDOW_DEPTH];
   logic [VAL_W-1:0]   srt_mem  [2][WINDOW_DEPTH];
   logic [VAL_W-1:0]   ring_q_ff;
   logic [VAL_W-1:0]   srt_q_ff;

   logic               ring_rd_en, ring_we;
   logic               srt_rd_en, srt_rd_sel, srt_we;
   logic [IDX_W-1:0]   srt_rd_idx, srt_wr_idx;
   logic [VAL_W-1:0]   srt_wr_data;

   logic               ema_start, ema_done;
   logic [AVG_W-1:0]   ema_result;

   logic               req_hit, frame_ok, full, issue, out_free;
   logic [VAL_W-1:0]   dec_calc, lat_calc, x_sel;
   logic [AVG_W-1:0]   avg_sel;
   logic [CNT_W-1:0]   ptr_dec;
   logic [FRAC_W:0]    frac_sum;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_hit  = req_chan.valid && req_chan.ready;
   assign frame_ok = (req_chan.decode_start_ms != '0) && (req_chan.decode_end_ms != '0);
   assign dec_calc = req_chan.decode_end_ms[VAL_W-1:0] - req_chan.decode_start_ms[VAL_W-1:0];
   assign lat_calc = ((req_chan.present_ms != '0) &&
                      (req_chan.present_ms >= req_chan.decode_end_ms)) ?
                     (req_chan.present_ms[VAL_W-1:0] - req_chan.decode_end_ms[VAL_W-1:0]) : '0;

   assign x_sel    = metric_ff ? lat_ff : dec_ff;
   assign avg_sel  = metric_ff ? pre_avg_ff : dec_avg_ff;
   assign full     = (used_ff == CNT_W'(WINDOW_DEPTH));
   assign ptr_dec  = ptr_ff - 1'b1;
   assign frac_sum = {1'b0, frac_ff} + (FRAC_W+1)'(P95_NUM);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   lepm_ema u_ema (
      .clock  (clock),
      .reset  (reset),
      .start  (ema_start),
      .first  (count_ff == '0),
      .alpha  (alpha_ff),
      .avg    (avg_sel),
      .sample (x_sel),
      .done   (ema_done),
      .result (ema_result)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      metric_in     = metric_ff;
      ptr_in        = ptr_ff;
      flag_in       = flag_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      alpha_in      = csr_wr_en ? csr_wr_data : alpha_ff;
      dec_avg_in    = dec_avg_ff;
      pre_avg_in    = pre_avg_ff;
      count_in      = count_ff;
      slot_in       = slot_ff;
      used_in       = used_ff;
      rank_in       = rank_ff;
      frac_in       = frac_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      dec_in        = dec_ff;
      lat_in        = lat_ff;
      p95_dec_in    = p95_dec_ff;
      o_avg_dec_in  = o_avg_dec_ff;
      o_avg_pre_in  = o_avg_pre_ff;
      o_p95_dec_in  = o_p95_dec_ff;
      o_p95_pre_in  = o_p95_pre_ff;
      o_last_dec_in = o_last_dec_ff;
      o_last_pre_in = o_last_pre_ff;
      o_count_in    = o_count_ff;
      ring_rd_en    = 1'b0;
      ring_we       = 1'b0;
      srt_rd_en     = 1'b0;
      srt_rd_sel    = metric_ff;
      srt_rd_idx    = '0;
      srt_we        = 1'b0;
      srt_wr_idx    = '0;
      srt_wr_data   = x_sel;
      ema_start     = 1'b0;
      issue         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_hit && frame_ok) begin
               dec_in    = dec_calc;
               lat_in    = lat_calc;
               metric_in = 1'b0;
               state_in  = S_EMA_GO;
            end
         end
         S_EMA_GO: begin
            // fetch the sample that leaves the window, if it is full
            ema_start  = 1'b1;
            ring_rd_en = full;
            state_in   = S_EMA_WT;
         end
         S_EMA_WT: begin
            if (ema_done) begin
               if (metric_ff) begin
                  pre_avg_in = ema_result;
               end else begin
                  dec_avg_in = ema_result;
               end
               ring_we = 1'b1;
               flag_in = 1'b0;
               if (full) begin
                  ptr_in   = '0;
                  state_in = S_DEL;
               end else begin
                  ptr_in   = used_ff;
                  state_in = S_INS;
               end
            end
         end
         S_DEL: begin
            // ascending scan; after the old sample is found, shift down by one
            issue      = (ptr_ff != used_ff);
            srt_rd_en  = issue;
            srt_rd_idx = ptr_ff[IDX_W-1:0];
            rd_vld_in  = issue;
            rd_idx_in  = ptr_ff[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (!flag_ff && (srt_q_ff == ring_q_ff)) begin
                  flag_in = 1'b1;
               end else if (flag_ff) begin
                  srt_we      = 1'b1;
                  srt_wr_idx  = rd_idx_ff - 1'b1;
                  srt_wr_data = srt_q_ff;
               end
            end
            if (!issue && !rd_vld_ff) begin
               ptr_in   = used_ff - 1'b1;
               flag_in  = 1'b0;
               state_in = S_INS;
            end
         end
         S_INS: begin
            // descending scan; larger entries move up until the new sample fits
            issue      = (ptr_ff != '0);
            srt_rd_en  = issue;
            srt_rd_idx = ptr_dec[IDX_W-1:0];
            rd_vld_in  = issue;
            rd_idx_in  = ptr_dec[IDX_W-1:0];
            if (issue) begin
               ptr_in = ptr_dec;
            end
            if (rd_vld_ff && !flag_ff) begin
               srt_we     = 1'b1;
               srt_wr_idx = rd_idx_ff + 1'b1;
               if (srt_q_ff > x_sel) begin
                  srt_wr_data = srt_q_ff;
               end else begin
                  srt_wr_data = x_sel;
                  flag_in     = 1'b1;
               end
            end
            if (!issue && !rd_vld_ff) begin
               state_in = S_INS_END;
            end
         end
         S_INS_END: begin
            // smallest so far goes to the bottom
            if (!flag_ff) begin
               srt_we     = 1'b1;
               srt_wr_idx = '0;
            end
            if (!metric_ff) begin
               metric_in = 1'b1;
               state_in  = S_EMA_GO;
            end else begin
               metric_in = 1'b0;
               slot_in   = (slot_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               if (used_ff == '0) begin
                  used_in = CNT_W'(1);
               end else if (!full) begin
                  used_in = used_ff + 1'b1;
                  if (frac_sum >= (FRAC_W+1)'(P95_DEN)) begin
                     frac_in = FRAC_W'(frac_sum - (FRAC_W+1)'(P95_DEN));
                     rank_in = rank_ff + 1'b1;
                  end else begin
                     frac_in = frac_sum[FRAC_W-1:0];
                  end
               end
               state_in = S_P95_A;
            end
         end
         S_P95_A: begin
            srt_rd_en  = 1'b1;
            srt_rd_sel = 1'b0;
            srt_rd_idx = rank_ff;
            state_in   = S_P95_B;
         end
         S_P95_B: begin
            srt_rd_en  = 1'b1;
            srt_rd_sel = 1'b1;
            srt_rd_idx = rank_ff;
            p95_dec_in = srt_q_ff;
            state_in   = S_P95_C;
         end
         S_P95_C: begin
            // hand the word to the output register once it is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               o_avg_dec_in  = dec_avg_ff;
               o_avg_pre_in  = pre_avg_ff;
               o_p95_dec_in  = p95_dec_ff;
               o_p95_pre_in  = srt_q_ff;
               o_last_dec_in = dec_ff;
               o_last_pre_in = lat_ff;
               o_count_in    = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         metric_ff    <= 1'b0;
         ptr_ff       <= '0;
         flag_ff      <= 1'b0;
         rd_vld_ff    <= 1'b0;
         alpha_ff     <= ALPHA_RESET;
         dec_avg_ff   <= '0;
         pre_avg_ff   <= '0;
         count_ff     <= '0;
         slot_ff      <= '0;
         used_ff      <= '0;
         rank_ff      <= '0;
         frac_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         metric_ff    <= metric_in;
         ptr_ff       <= ptr_in;
         flag_ff      <= flag_in;
         rd_vld_ff    <= rd_vld_in;
         alpha_ff     <= alpha_in;
         dec_avg_ff   <= dec_avg_in;
         pre_avg_ff   <= pre_avg_in;
         count_ff     <= count_in;
         slot_ff      <= slot_in;
         used_ff      <= used_in;
         rank_ff      <= rank_in;
         frac_ff      <= frac_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff        <= dec_in;
      lat_ff        <= lat_in;
      rd_idx_ff     <= rd_idx_in;
      p95_dec_ff    <= p95_dec_in;
      o_avg_dec_ff  <= o_avg_dec_in;
      o_avg_pre_ff  <= o_avg_pre_in;
      o_p95_dec_ff  <= o_p95_dec_in;
      o_p95_pre_ff  <= o_p95_pre_in;
      o_last_dec_ff <= o_last_dec_in;
      o_last_pre_ff <= o_last_pre_in;
      o_count_ff    <= o_count_in;
   end

   // ring memory
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[metric_ff][slot_ff] <= x_sel;
      end
      if (ring_rd_en) begin
         ring_q_ff <= ring_mem[metric_ff][slot_ff];
      end
   end

   // sorted memory
   always_ff @(posedge clock) begin
      if (srt_we) begin
         srt_mem[metric_ff][srt_wr_idx] <= srt_wr_data;
      end
      if (srt_rd_en) begin
         srt_q_ff <= srt_mem[srt_rd_sel][srt_rd_idx];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.avg_decode_q16  = o_avg_dec_ff;
   assign rsp_chan.avg_present_q16 = o_avg_pre_ff;
   assign rsp_chan.p95_decode      = o_p95_dec_ff;
   assign rsp_chan.p95_present     = o_p95_pre_ff;
   assign rsp_chan.last_decode     = o_last_dec_ff;
   assign rsp_chan.last_present    = o_last_pre_ff;
   assign rsp_chan.frames_timed    = o_count_ff;

   // checks
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      frac_ff < FRAC_W'(P95_DEN))
      else $error("rank fraction out of range");

   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window fill beyond depth");

   a_rank_in_fill: assert property (@(posedge clock) disable iff (reset)
      (used_ff != '0) |-> (CNT_W'(rank_ff) < used_ff))
      else $error("percentile rank outside filled window");

   a_ema_done_wait: assert property (@(posedge clock) disable iff (reset)
      ema_done |-> (state_ff == S_EMA_WT))
      else $error("average update finished outside its wait state");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready && (state_ff == S_P95_C)) |=> (state_ff == S_P95_C))
      else $error("result word dropped while output register busy");

endmodule

>>> src/lepm_ema.sv
// Exponential average update, one 16x16 multiply per cycle over three
// 16-bit chunks of the difference; the first sample is taken as the average directly.
module lepm_ema import lepm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               first,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [AVG_W-1:0]   avg,
   input  logic [VAL_W-1:0]   sample,
   output logic               done,
   output logic [AVG_W-1:0]   result
);

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_MUL  = 2'd1;
   localparam logic [1:0] E_FIN  = 2'd2;

   logic [1:0]           est_ff, est_in;
   logic [CHUNK_W-1:0]   k_ff, k_in;
   logic                 ge_ff, ge_in;
   logic [AVG_W-1:0]     diff_ff, diff_in;
   logic [AVG_W-1:0]     avg_ff, avg_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic                 done_ff, done_in;
   logic [AVG_W-1:0]     res_ff, res_in;

   logic [AVG_W-1:0]     target;
   logic [ALPHA_W-1:0]   chunk;
   logic [2*ALPHA_W-1:0] pp;
   logic [AVG_W-1:0]     step;
   logic                 rnd;

   assign target = {sample, {(AVG_W-VAL_W){1'b0}}};
   assign chunk  = diff_ff[ALPHA_W*k_ff +: ALPHA_W];
   assign pp     = alpha * chunk;
   assign step   = acc_ff[ACC_W-1:ALPHA_W];
   assign rnd    = |acc_ff[ALPHA_W-1:0];

   // sequencer: load, three partial products, final add or subtract
   always_comb begin
      est_in  = est_ff;
      k_in    = k_ff;
      ge_in   = ge_ff;
      diff_in = diff_ff;
      avg_in  = avg_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      case (est_ff)
         E_IDLE: begin
            if (start) begin
               if (first) begin
                  res_in  = target;
                  done_in = 1'b1;
               end else begin
                  ge_in   = (target >= avg);
                  diff_in = (target >= avg) ? (target - avg) : (avg - target);
                  avg_in  = avg;
                  acc_in  = '0;
                  k_in    = '0;
                  est_in  = E_MUL;
               end
            end
         end
         E_MUL: begin
            acc_in = acc_ff + (ACC_W'(pp) << (ALPHA_W * k_ff));
            if (k_ff == CHUNK_W'(CHUNKS - 1)) begin
               est_in = E_FIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         E_FIN: begin
            // floor rounding: a decrease rounds its magnitude up
            res_in  = ge_ff ? (avg_ff + step) : (avg_ff - step - AVG_W'(rnd));
            done_in = 1'b1;
            est_in  = E_IDLE;
         end
         default: est_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff  <= E_IDLE;
         done_ff <= 1'b0;
      end else begin
         est_ff  <= est_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      ge_ff   <= ge_in;
      diff_ff <= diff_in;
      avg_ff  <= avg_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
